>>> src/crlp_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded RC low-pass package
// Shared widths, register indexes and reset values for the filter block.
// ----------------------------------------------------------------------------
package crlp_pkg;

   localparam int MAX_STAGES_DEF = 8;

   localparam int DATA_W  = 16;   // sample width, signed
   localparam int ALPHA_W = 16;   // unsigned Q0.16
   localparam int COUNT_W = 4;    // stage count register width
   localparam int FRAC_W  = 8;    // fraction bits of a stage value
   localparam int STAGE_W = DATA_W + FRAC_W;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALPHA = 2'd0,
      REG_COUNT = 2'd1,
      REG_START = 2'd2
   } csr_reg_type;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'h8000;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
   localparam logic [DATA_W-1:0]  START_RESET = 16'h0000;

endpackage

>>> src/crlp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crlp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/cascaded_rc_lowpass.sv
// ----------------------------------------------------------------------------
// Cascaded RC low-pass filter
// Runs each sample through up to MAX_STAGES first-order low-pass stages.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the req_ channel (valid/ready) and one filtered item
// leaves on the rsp_ channel for every accepted sample. The stage values
// live in a small RAM that one shared multiplier walks through, stage by
// stage: a read, then a multiply step, then an update step that writes the
// stage back while the next stage is being read.
// The result is registered once the last active stage is updated, and a new
// sample is taken only after the previous one has left for the output
// register, so the single read-multiply-write loop sets the rate.
// The result sits in an output register, so a stalled receiver does not
// stop the next sample from being accepted; only the final handoff waits
// for the output register to free up.
// Reset puts the registers at their defaults and marks every stage as
// holding zero. Any write to a defined register reloads every stage with
// start_value through per-stage valid bits and a fill value. The user must
// write configuration only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cascaded_rc_lowpass
   import crlp_pkg::*;
#(
   parameter int MAX_STAGES = MAX_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_sample_out,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int PROD_W = STAGE_W + 1 + ALPHA_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_UPD,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [ALPHA_W-1:0]        alpha_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [DATA_W-1:0]         start_ff;
   logic signed [STAGE_W-1:0] fill_ff;
   logic [MAX_STAGES-1:0]     valid_ff;

   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          last_ff;
   logic signed [STAGE_W-1:0] u_ff;
   logic signed [STAGE_W-1:0] y_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_sample_ff;

   logic [IDX_W-1:0]          last_calc;
   logic                      csr_hit;
   logic [DATA_W-1:0]         start_new;
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [STAGE_W-1:0]        ram_q;
   logic signed [STAGE_W-1:0] stage_rd;
   logic signed [STAGE_W:0]   diff;
   logic signed [PROD_W-1:0]  product;
   logic signed [STAGE_W-1:0] y_new;
   logic                      at_last;

   // Effective stage count: zero counts as one, large values saturate.
   always_comb begin
      if (count_ff == '0) begin
         last_calc = '0;
      end else if (int'(count_ff) > MAX_STAGES) begin
         last_calc = IDX_W'(MAX_STAGES - 1);
      end else begin
         last_calc = IDX_W'(count_ff - COUNT_W'(1));
      end
   end

   assign csr_hit   = csr_index inside {REG_ALPHA, REG_COUNT, REG_START};
   assign start_new = (csr_index == REG_START) ? csr_wdata : start_ff;

   assign at_last     = (idx_ff == last_ff);
   assign ram_wr_en   = (state_ff == S_UPD);
   assign ram_rd_en   = (state_ff == S_READ) || ((state_ff == S_UPD) && !at_last);
   assign ram_rd_addr = (state_ff == S_READ) ? idx_ff : idx_ff + IDX_W'(1);

   // A stage never written since the last reload reads as the fill value.
   assign stage_rd = valid_ff[idx_ff] ? $signed(ram_q) : fill_ff;

   // y += floor(alpha * (u - y) / 2^16); the update stays between y and u.
   assign diff    = {u_ff[STAGE_W-1], u_ff} - {stage_rd[STAGE_W-1], stage_rd};
   assign product = PROD_W'(diff * $signed({1'b0, alpha_ff}));
   assign y_new   = y_ff + prod_ff[ALPHA_W +: STAGE_W];

   crlp_ram #(
      .WIDTH (STAGE_W),
      .DEPTH (MAX_STAGES)
   ) u_stage_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (y_new),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         count_ff     <= COUNT_RESET;
         start_ff     <= START_RESET;
         fill_ff      <= '0;
         valid_ff     <= '0;
         idx_ff       <= '0;
         last_ff      <= '0;
      end else begin
         // The output register fills from the done state and empties when
         // the receiver takes the item.
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  u_ff     <= {req_sample_in, FRAC_W'(0)};
                  last_ff  <= last_calc;
                  idx_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               y_ff     <= stage_rd;
               prod_ff  <= product;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               valid_ff[idx_ff] <= 1'b1;
               u_ff             <= y_new;
               if (at_last) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= S_MUL;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_sample_ff <= u_ff[FRAC_W +: DATA_W];
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // Register writes; any defined register reloads every stage.
         if (csr_write_en) begin
            case (csr_index)
               REG_ALPHA: alpha_ff <= csr_wdata;
               REG_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
               REG_START: start_ff <= csr_wdata;
               default: begin
               end
            endcase
            if (csr_hit) begin
               valid_ff <= '0;
               fill_ff  <= {start_new, FRAC_W'(0)};
            end
         end
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

>>> src/crlp_checker.sv
// ----------------------------------------------------------------------------
// Cascaded RC low-pass checker
// Port-level assertions on the filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
module crlp_checker
   import crlp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_sample_out
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item still valid after reset");

   // After an accepted item the block is not ready in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after an accepted item");

   // A result cannot appear in the cycle right after its item is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result item appeared too early");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled result item changed or dropped");

endmodule

bind cascaded_rc_lowpass crlp_checker u_crlp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

>>> tb/tb_cascaded_rc_lowpass.sv
// ----------------------------------------------------------------------------
// Cascaded RC low-pass filter testbench
// Drives samples through the filter with random idling on both channels.
// Every result is compared against a cycle-free fixed-point model of the
// stage cascade that is kept in step with every register write.
// ----------------------------------------------------------------------------
module tb_cascaded_rc_lowpass;
   import crlp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A write to this index is outside the register map and must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam logic [DATA_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [DATA_W-1:0] SAMPLE_MIN = 16'h8000;

   // The limit allows for heavy idling on both sides and is still far above
   // a correct run.
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 24;
   localparam int SEGMENTS      = 8;
   localparam int SEG_ITEMS     = 55;

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_sample_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic signed [DATA_W-1:0] rsp_sample_out;
   logic                     csr_write_en  = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index     = '0;
   logic [DATA_W-1:0]        csr_wdata     = '0;

   // Idling percentages for the current phase of the run.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // Filter state as the testbench expects it: register copies and the
   // 16.8 value held by every stage.
   logic [ALPHA_W-1:0]       filt_alpha = ALPHA_RESET;
   logic [COUNT_W-1:0]       filt_count = COUNT_RESET;
   logic [DATA_W-1:0]        filt_start = START_RESET;
   logic signed [STAGE_W-1:0] stage_acc [MAX_STAGES_DEF];

   // Filtered samples still owed by the block, oldest first.
   logic signed [DATA_W-1:0] filtered_q [$];

   cascaded_rc_lowpass dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Hard stop in case the block hangs somewhere.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding",
                  cycle_count, filtered_q.size());
         $display("** cascaded_rc_lowpass: FAILED **");
         $finish;
      end
   end

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // Every stage starts out at zero; a register write changes that below.
   initial begin
      foreach (stage_acc[i]) stage_acc[i] = '0;
   end

   // Mirrors a register write. Any defined register reloads all stages with
   // the start value as it stands after the write; an undefined index does
   // nothing at all.
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] val);
      case (idx)
         REG_ALPHA: filt_alpha = val[ALPHA_W-1:0];
         REG_COUNT: filt_count = val[COUNT_W-1:0];
         REG_START: filt_start = val;
         default: return;
      endcase
      foreach (stage_acc[i]) stage_acc[i] = {filt_start, {FRAC_W{1'b0}}};
   endfunction

   // Runs one sample through the active stages and returns the filtered
   // sample. Each stage moves toward its input by alpha times the gap, the
   // product floored by the shift; the next stage sees the updated value.
   function automatic logic signed [DATA_W-1:0] run_cascade(
         input logic signed [DATA_W-1:0] x);
      int     n_used;
      longint u;
      longint y;
      longint prod;
      longint whole;
      n_used = int'(filt_count);
      if (n_used == 0) n_used = 1;
      if (n_used > MAX_STAGES_DEF) n_used = MAX_STAGES_DEF;
      u = longint'(x) * 256;
      y = 0;
      for (int n = 0; n < n_used; n++) begin
         y = longint'(stage_acc[n]);
         prod = longint'(filt_alpha) * (u - y);
         y = y + (prod >>> 16);
         stage_acc[n] = y[STAGE_W-1:0];
         u = y;
      end
      whole = y >>> FRAC_W;
      return whole[DATA_W-1:0];
   endfunction

   // Compares every accepted result with the oldest filtered sample owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_sample_out));
         end else begin
            if (rsp_sample_out !== filtered_q[0]) begin
               report_mismatch($sformatf("sample_out got %0d expected %0d",
                                         rsp_sample_out, filtered_q[0]));
            end
            void'(filtered_q.pop_front());
         end
      end
   end

   // Sends one sample. Valid is raised after an optional random gap and held
   // until the block takes the item; it is not lowered here, so a following
   // item can go out in the very next cycle.
   task automatic send_sample(input logic signed [DATA_W-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filtered_q.push_back(run_cascade(s));
   endtask

   // Stops sending and waits until every owed result has been taken, then
   // lets the block come to rest.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes are only issued while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      apply_reg(idx, val);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_level();
      case ($urandom_range(0, 4))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Alpha is drawn from the extremes, from very slow filters, from the upper
   // three quarters of the range and from the whole range.
   function automatic logic [DATA_W-1:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'hFFFF;
         2: return DATA_W'($urandom_range(1, 255));
         3: return DATA_W'($urandom_range(16384, 65535));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // The reset settings: half alpha, one stage, all stages at zero.
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      wait_drain();
   endtask

   // Alpha zero must hold every stage; full-scale alpha tracks almost fully.
   task automatic test_alpha_extremes();
      write_reg(REG_COUNT, 16'd3);
      write_reg(REG_ALPHA, '0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      wait_drain();
      write_reg(REG_ALPHA, 16'hFFFF);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      wait_drain();
   endtask

   // A count of zero acts as one stage, counts above the maximum saturate,
   // and bits above the count field are ignored.
   task automatic test_stage_count_limits();
      write_reg(REG_ALPHA, 16'd40000);
      write_reg(REG_COUNT, 16'd0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      wait_drain();
      write_reg(REG_COUNT, 16'd15);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      wait_drain();
      write_reg(REG_COUNT, 16'hFFF8);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd12345);
      wait_drain();
      write_reg(REG_COUNT, 16'd1);
      send_sample(-16'sd20000);
      wait_drain();
   endtask

   // Each defined register reloads the stages with the start value, while a
   // write to the unused index leaves them where the last sample put them.
   task automatic test_start_reload();
      write_reg(REG_COUNT, 16'd8);
      write_reg(REG_START, SAMPLE_MIN);
      write_reg(REG_ALPHA, 16'hFFFF);
      send_sample(SAMPLE_MAX);
      wait_drain();
      write_reg(REG_START, SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      wait_drain();
      write_reg(REG_UNUSED, 16'hFFFF);
      send_sample('0);
      wait_drain();
   endtask

   // Long random stretches. Each segment starts from a fresh configuration
   // and then feeds step-like input: a level is held for a while so the
   // cascade settles, with occasional full-range noise in between.
   task automatic test_random_stream(input int send_pct, input int stall_pct);
      logic [DATA_W-1:0] level;
      logic [DATA_W-1:0] cnt_word;
      logic [DATA_W-1:0] s;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      level = '0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drain();
         write_reg(REG_ALPHA, pick_alpha());
         cnt_word = DATA_W'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            cnt_word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 15));
         end else begin
            cnt_word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, MAX_STAGES_DEF));
         end
         write_reg(REG_COUNT, cnt_word);
         write_reg(REG_START, pick_level());
         if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DATA_W'($urandom));
         for (int k = 0; k < SEG_ITEMS; k++) begin
            // Once per phase the sender stops until the block is empty.
            if (seg == 3 && k == SEG_ITEMS / 2) wait_drain();
            if ($urandom_range(0, 7) == 0) level = pick_level();
            if ($urandom_range(0, 5) == 0) s = DATA_W'($urandom);
            else s = level;
            send_sample(s);
         end
      end
      wait_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_alpha_extremes();
      test_stage_count_limits();
      test_start_reload();

      test_random_stream(0, 0);
      test_random_stream(62, 0);
      test_random_stream(0, 62);
      test_random_stream(37, 37);

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && filtered_q.size() == 0) begin
         $display("** cascaded_rc_lowpass: PASSED **");
      end else begin
         $display("** cascaded_rc_lowpass: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
src/crlp_pkg.sv
src/crlp_ram.sv
src/cascaded_rc_lowpass.sv
src/crlp_checker.sv
tb/tb_cascaded_rc_lowpass.sv
